[src/nobf_pkg.sv]
package nobf_pkg;

   // Field widths
   localparam int unsigned TS_W       = 64;
   localparam int unsigned SEC_W      = 32;
   localparam int unsigned FRAC_W     = 32;
   localparam int unsigned GAIN_W     = 17;
   localparam int unsigned RTT_W      = 32;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_IDX_W  = 1;

   // Timestamp conversion constants
   localparam int unsigned     US_W         = 20;
   localparam logic [US_W-1:0] US_PER_S     = 20'd1000000;
   localparam logic [TS_W-1:0] NTP_EPOCH_US = 64'd2208988800000000;
   localparam int unsigned     PROD_W       = SEC_W + US_W;

   // Register reset values
   localparam logic [GAIN_W-1:0] GAIN_RESET = 17'd6554;
   localparam logic [RTT_W-1:0]  RTT_RESET  = 32'd20000;

   // Register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN    = 1'b0,
      CSR_MAX_RTT = 1'b1
   } csr_index_type;

   // One exchange after offset and delay evaluation
   typedef struct packed {
      logic            accepted;
      logic [TS_W-1:0] offset;
      logic [TS_W-1:0] delay;
   } sample_type;

   // Burst close request towards the smoothing stage
   typedef struct packed {
      logic            update;
      logic [TS_W-1:0] best_offset;
   } close_type;

   // Smoothed offset status after one item
   typedef struct packed {
      logic            updated;
      logic            known;
      logic [TS_W-1:0] filtered;
   } smooth_type;

endpackage

[src/nobf_ts_conv.sv]
module nobf_ts_conv (
   input  logic [nobf_pkg::SEC_W-1:0]  seconds,
   input  logic [nobf_pkg::FRAC_W-1:0] fraction,
   output logic [nobf_pkg::TS_W-1:0]   time_us
);

   logic [nobf_pkg::PROD_W-1:0] sec_prod;
   logic [nobf_pkg::PROD_W-1:0] frac_prod;

   // Scale seconds and fraction to microseconds
   assign sec_prod  = nobf_pkg::PROD_W'(seconds) * nobf_pkg::PROD_W'(nobf_pkg::US_PER_S);
   assign frac_prod = nobf_pkg::PROD_W'(fraction) * nobf_pkg::PROD_W'(nobf_pkg::US_PER_S);

   // Shift the era to 1970 with 64-bit wrap and add the sub-second part
   assign time_us = nobf_pkg::TS_W'(sec_prod) - nobf_pkg::NTP_EPOCH_US
                    + nobf_pkg::TS_W'(frac_prod[nobf_pkg::PROD_W-1:nobf_pkg::FRAC_W]);

endmodule

[src/nobf_burst_sel.sv]
module nobf_burst_sel (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  logic [nobf_pkg::RTT_W-1:0]   max_rtt,
   input  logic                         exchange_ok,
   input  logic                         last_in_burst,
   input  logic [nobf_pkg::TS_W-1:0]    t1,
   input  logic [nobf_pkg::TS_W-1:0]    t2,
   input  logic [nobf_pkg::TS_W-1:0]    t3,
   input  logic [nobf_pkg::TS_W-1:0]    t4,
   output nobf_pkg::sample_type         sample,
   output nobf_pkg::close_type          close
);

   logic [nobf_pkg::TS_W-1:0] sum;
   logic [nobf_pkg::TS_W-1:0] half_in;
   logic [nobf_pkg::TS_W-1:0] offset;
   logic [nobf_pkg::TS_W-1:0] delay;
   logic                      accepted;
   logic                      take;
   logic                      has_now;
   logic [nobf_pkg::TS_W-1:0] best_offset_now;
   logic [nobf_pkg::TS_W-1:0] best_delay_now;

   logic                      has_ff;
   logic                      has_in;
   logic [nobf_pkg::TS_W-1:0] best_delay_ff;
   logic [nobf_pkg::TS_W-1:0] best_delay_in;
   logic [nobf_pkg::TS_W-1:0] best_offset_ff;
   logic [nobf_pkg::TS_W-1:0] best_offset_in;

   // Offset: halve the wrapped sum, rounding toward zero
   assign sum     = (t2 - t1) + (t3 - t4);
   assign half_in = sum + nobf_pkg::TS_W'(sum[nobf_pkg::TS_W-1]);
   assign offset  = {sum[nobf_pkg::TS_W-1], half_in[nobf_pkg::TS_W-1:1]};

   // Round trip delay and acceptance
   assign delay    = (t4 - t1) - (t3 - t2);
   assign accepted = exchange_ok && (delay <= nobf_pkg::TS_W'(max_rtt));

   // Keep the first sample with the smallest delay
   assign take            = accepted && (!has_ff || (delay < best_delay_ff));
   assign has_now         = has_ff || take;
   assign best_offset_now = take ? offset : best_offset_ff;
   assign best_delay_now  = take ? delay : best_delay_ff;

   assign sample.accepted  = accepted;
   assign sample.offset    = offset;
   assign sample.delay     = delay;
   assign close.update      = last_in_burst && has_now;
   assign close.best_offset = best_offset_now;

   // Clear the burst on its last beat, else carry the best so far
   always_comb begin
      if (last_in_burst) begin
         has_in         = 1'b0;
         best_delay_in  = '1;
         best_offset_in = '0;
      end else begin
         has_in         = has_now;
         best_delay_in  = best_delay_now;
         best_offset_in = best_offset_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         has_ff         <= 1'b0;
         best_delay_ff  <= '1;
         best_offset_ff <= '0;
      end else if (step) begin
         has_ff         <= has_in;
         best_delay_ff  <= best_delay_in;
         best_offset_ff <= best_offset_in;
      end
   end

   // An empty burst sits at its cleared values
   assert property (@(posedge clock) disable iff (reset)
      !has_ff |-> (best_delay_ff == '1) && (best_offset_ff == '0))
      else $error("empty burst holds stale best sample");

   // A closing beat always leaves the burst empty
   assert property (@(posedge clock) disable iff (reset)
      step && last_in_burst |=> !has_ff)
      else $error("burst not cleared after last beat");

   // Hold the burst state while the stage is stalled
   assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(has_ff) && $stable(best_delay_ff) && $stable(best_offset_ff))
      else $error("burst state moved without a beat");

endmodule

[src/nobf_smooth.sv]
module nobf_smooth #(
   parameter int GAIN_FRAC_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  logic [nobf_pkg::GAIN_W-1:0]  gain,
   input  nobf_pkg::close_type          close,
   output nobf_pkg::smooth_type         result
);

   localparam int F  = GAIN_FRAC_BITS;
   localparam int TW = nobf_pkg::TS_W;
   localparam int GW = nobf_pkg::GAIN_W;
   localparam int AW = (F + 1 > GW) ? F + 1 : GW;
   localparam int PW = TW + 1 + AW + 1;
   localparam int SW = TW + F + 2;
   localparam logic [AW-1:0] GAIN_ONE = AW'(1) << F;

   logic [AW-1:0]        gain_ext;
   logic [AW-1:0]        gain_sat;
   logic signed [TW:0]   diff;
   logic signed [PW-1:0] prod;
   logic signed [SW-1:0] base;
   logic signed [SW-1:0] total;
   logic [SW-1:0]        rounded;
   logic [TW-1:0]        smoothed;

   logic [TW-1:0] filtered_ff;
   logic [TW-1:0] filtered_in;
   logic          known_ff;
   logic          known_in;

   // Saturate the gain at one
   assign gain_ext = AW'(gain);
   assign gain_sat = (gain_ext > GAIN_ONE) ? GAIN_ONE : gain_ext;

   // a*new + (1-a)*old, formed as old*2^F + a*(new-old)
   assign diff  = $signed({close.best_offset[TW-1], close.best_offset})
                  - $signed({filtered_ff[TW-1], filtered_ff});
   assign prod  = diff * $signed({1'b0, gain_sat});
   assign base  = $signed({{(SW-TW-F){filtered_ff[TW-1]}}, filtered_ff, {F{1'b0}}});
   assign total = base + $signed(prod[SW-1:0]);

   // Drop the fraction, rounding toward zero
   assign rounded  = total + (total[SW-1] ? SW'(GAIN_ONE - AW'(1)) : SW'(0));
   assign smoothed = rounded[F+TW-1:F];

   // Load on the first closed burst, smooth afterwards
   always_comb begin
      filtered_in = filtered_ff;
      known_in    = known_ff;
      if (close.update) begin
         known_in = 1'b1;
         if (known_ff) begin
            filtered_in = smoothed;
         end else begin
            filtered_in = close.best_offset;
         end
      end
   end

   assign result.updated  = close.update;
   assign result.known    = known_in;
   assign result.filtered = filtered_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         filtered_ff <= '0;
         known_ff    <= 1'b0;
      end else if (step) begin
         filtered_ff <= filtered_in;
         known_ff    <= known_in;
      end
   end

   // Once known, the offset stays known
   assert property (@(posedge clock) disable iff (reset)
      known_ff |=> known_ff)
      else $error("offset known flag dropped");

   // An update always leaves a known offset behind
   assert property (@(posedge clock) disable iff (reset)
      step && close.update |=> known_ff && (filtered_ff == $past(filtered_in)))
      else $error("smoothed offset update lost");

   // Hold the smoothed state while the stage is stalled
   assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(filtered_ff) && $stable(known_ff))
      else $error("smoothed state moved without a beat");

endmodule

[src/ntp_offset_burst_filter_core.sv]
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_ready  one NTP exchange (T1..T4, status, burst end)
// rsp_      out        rsp_valid / rsp_ready  sample offset and delay, smoothed offset
// csr_      in         csr_we                 gain (index 0), round trip limit (index 1)
//
// Takes one exchange per cycle unless rsp_ready holds the result register.
// Pipeline: input register, timestamp conversion, sample and burst selection, smoothing
// (one 65x18 gain multiply) into the result register.
// Each stage holds while the next is full; bubbles close up, so a stalled result
// register does not block the input until every stage is occupied.
// Synchronous active-high reset clears valids, burst state, smoothed offset; resets CSRs.
module ntp_offset_burst_filter_core #(
   parameter int GAIN_FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_exchange_ok,
   input  logic [nobf_pkg::TS_W-1:0]         req_send_time_us,
   input  logic [nobf_pkg::SEC_W-1:0]        req_server_rx_seconds,
   input  logic [nobf_pkg::FRAC_W-1:0]       req_server_rx_fraction,
   input  logic [nobf_pkg::SEC_W-1:0]        req_server_tx_seconds,
   input  logic [nobf_pkg::FRAC_W-1:0]       req_server_tx_fraction,
   input  logic [nobf_pkg::TS_W-1:0]         req_recv_time_us,
   input  logic                              req_last_in_burst,

   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_sample_accepted,
   output logic signed [nobf_pkg::TS_W-1:0]  rsp_sample_offset_us,
   output logic [nobf_pkg::TS_W-1:0]         rsp_sample_delay_us,
   output logic                              rsp_smoothed_updated,
   output logic signed [nobf_pkg::TS_W-1:0]  rsp_smoothed_offset_us,
   output logic                              rsp_offset_known,

   input  logic                              csr_we,
   input  logic [nobf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [nobf_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int TW = nobf_pkg::TS_W;

   // Configuration registers
   logic [nobf_pkg::GAIN_W-1:0] gain_ff;
   logic [nobf_pkg::GAIN_W-1:0] gain_in;
   logic [nobf_pkg::RTT_W-1:0]  max_rtt_ff;
   logic [nobf_pkg::RTT_W-1:0]  max_rtt_in;

   // Handshake chain
   logic req_fire;
   logic rsp_free;
   logic s3_free;
   logic s2_free;
   logic adv1;
   logic adv2;
   logic adv3;

   // Input stage
   logic                          s1_valid_ff;
   logic                          s1_valid_in;
   logic                          s1_ok_ff;
   logic [TW-1:0]                 s1_t1_ff;
   logic [nobf_pkg::SEC_W-1:0]    s1_rx_sec_ff;
   logic [nobf_pkg::FRAC_W-1:0]   s1_rx_frac_ff;
   logic [nobf_pkg::SEC_W-1:0]    s1_tx_sec_ff;
   logic [nobf_pkg::FRAC_W-1:0]   s1_tx_frac_ff;
   logic [TW-1:0]                 s1_t4_ff;
   logic                          s1_last_ff;
   logic [TW-1:0]                 t2_us;
   logic [TW-1:0]                 t3_us;

   // Converted timestamps
   logic          s2_valid_ff;
   logic          s2_valid_in;
   logic          s2_ok_ff;
   logic          s2_last_ff;
   logic [TW-1:0] s2_t1_ff;
   logic [TW-1:0] s2_t2_ff;
   logic [TW-1:0] s2_t3_ff;
   logic [TW-1:0] s2_t4_ff;

   // Evaluated sample
   nobf_pkg::sample_type sample;
   nobf_pkg::close_type  close;
   logic                 s3_valid_ff;
   logic                 s3_valid_in;
   nobf_pkg::sample_type s3_sample_ff;
   nobf_pkg::close_type  s3_close_ff;

   // Result register
   nobf_pkg::smooth_type smooth;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic                 rsp_accepted_ff;
   logic [TW-1:0]        rsp_offset_ff;
   logic [TW-1:0]        rsp_delay_ff;
   logic                 rsp_updated_ff;
   logic [TW-1:0]        rsp_smoothed_ff;
   logic                 rsp_known_ff;

   // Write configuration; unknown indexes are dropped
   always_comb begin
      gain_in    = gain_ff;
      max_rtt_in = max_rtt_ff;
      if (csr_we) begin
         case (nobf_pkg::csr_index_type'(csr_index))
            nobf_pkg::CSR_GAIN: begin
               gain_in = csr_wdata[nobf_pkg::GAIN_W-1:0];
            end
            nobf_pkg::CSR_MAX_RTT: begin
               max_rtt_in = csr_wdata[nobf_pkg::RTT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff    <= nobf_pkg::GAIN_RESET;
         max_rtt_ff <= nobf_pkg::RTT_RESET;
      end else begin
         gain_ff    <= gain_in;
         max_rtt_ff <= max_rtt_in;
      end
   end

   // Advance each stage when the next one has room
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign adv3      = s3_valid_ff && rsp_free;
   assign s3_free   = !s3_valid_ff || rsp_free;
   assign adv2      = s2_valid_ff && s3_free;
   assign s2_free   = !s2_valid_ff || s3_free;
   assign adv1      = s1_valid_ff && s2_free;
   assign req_ready = !s1_valid_ff || s2_free;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      s1_valid_in  = req_fire ? 1'b1 : (adv1 ? 1'b0 : s1_valid_ff);
      s2_valid_in  = adv1 ? 1'b1 : (adv2 ? 1'b0 : s2_valid_ff);
      s3_valid_in  = adv2 ? 1'b1 : (adv3 ? 1'b0 : s3_valid_ff);
      rsp_valid_in = adv3 ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the request beat
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ok_ff      <= req_exchange_ok;
         s1_t1_ff      <= req_send_time_us;
         s1_rx_sec_ff  <= req_server_rx_seconds;
         s1_rx_frac_ff <= req_server_rx_fraction;
         s1_tx_sec_ff  <= req_server_tx_seconds;
         s1_tx_frac_ff <= req_server_tx_fraction;
         s1_t4_ff      <= req_recv_time_us;
         s1_last_ff    <= req_last_in_burst;
      end
   end

   // Convert server timestamps to Unix microseconds
   nobf_ts_conv u_conv_rx (
      .seconds  (s1_rx_sec_ff),
      .fraction (s1_rx_frac_ff),
      .time_us  (t2_us)
   );

   nobf_ts_conv u_conv_tx (
      .seconds  (s1_tx_sec_ff),
      .fraction (s1_tx_frac_ff),
      .time_us  (t3_us)
   );

   always_ff @(posedge clock) begin
      if (adv1) begin
         s2_ok_ff   <= s1_ok_ff;
         s2_last_ff <= s1_last_ff;
         s2_t1_ff   <= s1_t1_ff;
         s2_t2_ff   <= t2_us;
         s2_t3_ff   <= t3_us;
         s2_t4_ff   <= s1_t4_ff;
      end
   end

   // Evaluate the sample and track the burst minimum
   nobf_burst_sel u_burst_sel (
      .clock         (clock),
      .reset         (reset),
      .step          (adv2),
      .max_rtt       (max_rtt_ff),
      .exchange_ok   (s2_ok_ff),
      .last_in_burst (s2_last_ff),
      .t1            (s2_t1_ff),
      .t2            (s2_t2_ff),
      .t3            (s2_t3_ff),
      .t4            (s2_t4_ff),
      .sample        (sample),
      .close         (close)
   );

   always_ff @(posedge clock) begin
      if (adv2) begin
         s3_sample_ff <= sample;
         s3_close_ff  <= close;
      end
   end

   // Smooth the burst offset
   nobf_smooth #(
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_smooth (
      .clock  (clock),
      .reset  (reset),
      .step   (adv3),
      .gain   (gain_ff),
      .close  (s3_close_ff),
      .result (smooth)
   );

   // Load the result register
   always_ff @(posedge clock) begin
      if (adv3) begin
         rsp_accepted_ff <= s3_sample_ff.accepted;
         rsp_offset_ff   <= s3_sample_ff.offset;
         rsp_delay_ff    <= s3_sample_ff.delay;
         rsp_updated_ff  <= smooth.updated;
         rsp_smoothed_ff <= smooth.filtered;
         rsp_known_ff    <= smooth.known;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_sample_accepted    = rsp_accepted_ff;
   assign rsp_sample_offset_us   = $signed(rsp_offset_ff);
   assign rsp_sample_delay_us    = rsp_delay_ff;
   assign rsp_smoothed_updated   = rsp_updated_ff;
   assign rsp_smoothed_offset_us = $signed(rsp_smoothed_ff);
   assign rsp_offset_known       = rsp_known_ff;

   // An updated result always carries a known offset
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_updated_ff |-> rsp_known_ff)
      else $error("smoothed update without known offset");

   // A stalled input stage keeps its beat
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s2_free && !req_fire |=> s1_valid_ff && $stable(s1_t1_ff))
      else $error("input stage lost a stalled beat");

   // A sample leaving the last stage lands in the result register
   assert property (@(posedge clock) disable iff (reset)
      adv3 |=> rsp_valid_ff && (rsp_delay_ff == $past(s3_sample_ff.delay)))
      else $error("result register missed a beat");

   // Every accepted request occupies the input stage
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> s1_valid_ff)
      else $error("accepted request not held");

endmodule

[sim/offset_filter_checker.sv]
module offset_filter_checker (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic                              req_exchange_ok,
   input  logic [nobf_pkg::TS_W-1:0]         req_send_time_us,
   input  logic [nobf_pkg::SEC_W-1:0]        req_server_rx_seconds,
   input  logic [nobf_pkg::FRAC_W-1:0]       req_server_rx_fraction,
   input  logic [nobf_pkg::SEC_W-1:0]        req_server_tx_seconds,
   input  logic [nobf_pkg::FRAC_W-1:0]       req_server_tx_fraction,
   input  logic [nobf_pkg::TS_W-1:0]         req_recv_time_us,
   input  logic                              req_last_in_burst,

   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic                              rsp_sample_accepted,
   input  logic signed [nobf_pkg::TS_W-1:0]  rsp_sample_offset_us,
   input  logic [nobf_pkg::TS_W-1:0]         rsp_sample_delay_us,
   input  logic                              rsp_smoothed_updated,
   input  logic signed [nobf_pkg::TS_W-1:0]  rsp_smoothed_offset_us,
   input  logic                              rsp_offset_known,

   input  logic                              csr_we,
   input  logic [nobf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [nobf_pkg::CSR_DATA_W-1:0]   csr_wdata,

   output int                                mismatch_count,
   output int                                results_pending
);

   localparam int unsigned GAIN_FRAC_BITS = 16;
   localparam logic [nobf_pkg::GAIN_W-1:0] UNITY_GAIN =
      nobf_pkg::GAIN_W'(1 << GAIN_FRAC_BITS);
   localparam logic [nobf_pkg::TS_W-1:0] NTP_TO_UNIX_S = 64'd2208988800;
   localparam logic [nobf_pkg::TS_W-1:0] MICROS        = 64'd1000000;

   // One predicted result beat
   typedef struct packed {
      nobf_pkg::sample_type meas;
      nobf_pkg::smooth_type status;
   } exchange_result_type;

   exchange_result_type pending_results[$];

   // Register copies and filter state
   logic [nobf_pkg::GAIN_W-1:0] gain_q16;
   logic [nobf_pkg::RTT_W-1:0]  round_trip_limit;
   logic [nobf_pkg::TS_W-1:0]   best_delay;
   logic [nobf_pkg::TS_W-1:0]   best_offset;
   logic                        burst_has_sample;
   logic [nobf_pkg::TS_W-1:0]   filtered_offset;
   logic                        offset_known;
   int                          fail_tally;

   // NTP seconds and fraction to Unix microseconds, wrapping at 64 bits
   function automatic logic [nobf_pkg::TS_W-1:0] ntp_time_us(
      logic [nobf_pkg::SEC_W-1:0] secs, logic [nobf_pkg::FRAC_W-1:0] frac);
      logic [nobf_pkg::TS_W-1:0] whole;
      logic [nobf_pkg::TS_W-1:0] part;
      whole = (nobf_pkg::TS_W'(secs) - NTP_TO_UNIX_S) * MICROS;
      part  = (nobf_pkg::TS_W'(frac) * MICROS) >> nobf_pkg::FRAC_W;
      return whole + part;
   endfunction

   // Weighted mix of new and old offset, exact in 128 bits, truncated toward zero
   function automatic logic [nobf_pkg::TS_W-1:0] blend_offset(
      logic [nobf_pkg::TS_W-1:0] fresh, logic [nobf_pkg::TS_W-1:0] prior,
      logic [nobf_pkg::GAIN_W-1:0] gain);
      logic signed [127:0] fresh_w;
      logic signed [127:0] prior_w;
      logic signed [127:0] weight_new;
      logic signed [127:0] weight_old;
      logic signed [127:0] acc;
      fresh_w    = 128'($signed(fresh));
      prior_w    = 128'($signed(prior));
      weight_new = 128'((gain > UNITY_GAIN) ? UNITY_GAIN : gain);
      weight_old = UNITY_GAIN - weight_new;
      acc        = fresh_w * weight_new + prior_w * weight_old;
      acc        = acc / (2 ** GAIN_FRAC_BITS);
      return acc[nobf_pkg::TS_W-1:0];
   endfunction

   // Evaluate one exchange and advance the burst and smoothing state
   function automatic exchange_result_type filter_exchange(
      logic ok, logic [nobf_pkg::TS_W-1:0] t1,
      logic [nobf_pkg::SEC_W-1:0] rx_sec, logic [nobf_pkg::FRAC_W-1:0] rx_frac,
      logic [nobf_pkg::SEC_W-1:0] tx_sec, logic [nobf_pkg::FRAC_W-1:0] tx_frac,
      logic [nobf_pkg::TS_W-1:0] t4, logic closes);
      logic [nobf_pkg::TS_W-1:0] t2;
      logic [nobf_pkg::TS_W-1:0] t3;
      logic [nobf_pkg::TS_W-1:0] sum;
      exchange_result_type       r;
      t2 = ntp_time_us(rx_sec, rx_frac);
      t3 = ntp_time_us(tx_sec, tx_frac);
      sum = (t2 - t1) + (t3 - t4);
      r.meas.offset   = $signed(sum) / 64'sd2;
      r.meas.delay    = (t4 - t1) - (t3 - t2);
      r.meas.accepted = ok && (r.meas.delay <= nobf_pkg::TS_W'(round_trip_limit));
      r.status.updated = 1'b0;

      // keep the first sample with the smallest delay
      if (r.meas.accepted && (!burst_has_sample || r.meas.delay < best_delay)) begin
         best_delay       = r.meas.delay;
         best_offset      = r.meas.offset;
         burst_has_sample = 1'b1;
      end

      // close the burst: load or smooth, then clear the burst
      if (closes) begin
         if (burst_has_sample) begin
            filtered_offset = offset_known ?
                              blend_offset(best_offset, filtered_offset, gain_q16) :
                              best_offset;
            offset_known     = 1'b1;
            r.status.updated = 1'b1;
         end
         best_delay       = '1;
         best_offset      = '0;
         burst_has_sample = 1'b0;
      end

      r.status.filtered = filtered_offset;
      r.status.known    = offset_known;
      return r;
   endfunction

   always @(posedge clock) begin
      exchange_result_type want;
      exchange_result_type predicted;
      if (reset) begin
         pending_results.delete();
         gain_q16         = nobf_pkg::GAIN_RESET;
         round_trip_limit = nobf_pkg::RTT_RESET;
         best_delay       = '1;
         best_offset      = '0;
         burst_has_sample = 1'b0;
         filtered_offset  = '0;
         offset_known     = 1'b0;
         fail_tally       = 0;
      end else begin
         // compare each result beat with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $error("result beat with no exchange outstanding");
               fail_tally++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_sample_accepted !== want.meas.accepted) begin
                  $error("sample_accepted: expected %0b, got %0b",
                         want.meas.accepted, rsp_sample_accepted);
                  fail_tally++;
               end
               if (rsp_sample_offset_us !== want.meas.offset) begin
                  $error("sample_offset_us: expected %0d, got %0d",
                         $signed(want.meas.offset), rsp_sample_offset_us);
                  fail_tally++;
               end
               if (rsp_sample_delay_us !== want.meas.delay) begin
                  $error("sample_delay_us: expected %0d, got %0d",
                         want.meas.delay, rsp_sample_delay_us);
                  fail_tally++;
               end
               if (rsp_smoothed_updated !== want.status.updated) begin
                  $error("smoothed_updated: expected %0b, got %0b",
                         want.status.updated, rsp_smoothed_updated);
                  fail_tally++;
               end
               if (rsp_smoothed_offset_us !== want.status.filtered) begin
                  $error("smoothed_offset_us: expected %0d, got %0d",
                         $signed(want.status.filtered), rsp_smoothed_offset_us);
                  fail_tally++;
               end
               if (rsp_offset_known !== want.status.known) begin
                  $error("offset_known: expected %0b, got %0b",
                         want.status.known, rsp_offset_known);
                  fail_tally++;
               end
            end
         end

         // predict each accepted exchange beat
         if (req_valid && req_ready) begin
            predicted = filter_exchange(req_exchange_ok, req_send_time_us,
                                        req_server_rx_seconds,
                                        req_server_rx_fraction,
                                        req_server_tx_seconds,
                                        req_server_tx_fraction,
                                        req_recv_time_us, req_last_in_burst);
            pending_results = {pending_results, predicted};
         end

         // mirror register writes
         if (csr_we) begin
            case (csr_index)
               nobf_pkg::CSR_GAIN:    gain_q16         = csr_wdata[nobf_pkg::GAIN_W-1:0];
               nobf_pkg::CSR_MAX_RTT: round_trip_limit = csr_wdata[nobf_pkg::RTT_W-1:0];
               default: begin
               end
            endcase
         end
      end
      mismatch_count  <= fail_tally;
      results_pending <= pending_results.size();
   end

endmodule

[sim/tb_top.sv]
module tb_top;

   localparam int CLK_PERIOD      = 12;
   localparam int RESET_CYCLES    = 10;
   localparam int TIMEOUT_CYCLES  = 400000;
   localparam int RANDOM_ITEMS    = 1000;
   localparam int SETTING_PHASES  = 5;
   localparam int HOLD_OFF_CYCLES = 60;
   localparam int DRAIN_CYCLES    = 4;

   // One NTP exchange as offered on the request channel
   typedef struct packed {
      logic                        ok;
      logic [nobf_pkg::TS_W-1:0]   t1;
      logic [nobf_pkg::SEC_W-1:0]  rx_sec;
      logic [nobf_pkg::FRAC_W-1:0] rx_frac;
      logic [nobf_pkg::SEC_W-1:0]  tx_sec;
      logic [nobf_pkg::FRAC_W-1:0] tx_frac;
      logic [nobf_pkg::TS_W-1:0]   t4;
      logic                        closes;
   } exchange_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;

   logic                             req_valid              = 1'b0;
   logic                             req_ready;
   logic                             req_exchange_ok        = 1'b0;
   logic [nobf_pkg::TS_W-1:0]        req_send_time_us       = '0;
   logic [nobf_pkg::SEC_W-1:0]       req_server_rx_seconds  = '0;
   logic [nobf_pkg::FRAC_W-1:0]      req_server_rx_fraction = '0;
   logic [nobf_pkg::SEC_W-1:0]       req_server_tx_seconds  = '0;
   logic [nobf_pkg::FRAC_W-1:0]      req_server_tx_fraction = '0;
   logic [nobf_pkg::TS_W-1:0]        req_recv_time_us       = '0;
   logic                             req_last_in_burst      = 1'b0;

   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic                             rsp_sample_accepted;
   logic signed [nobf_pkg::TS_W-1:0] rsp_sample_offset_us;
   logic [nobf_pkg::TS_W-1:0]        rsp_sample_delay_us;
   logic                             rsp_smoothed_updated;
   logic signed [nobf_pkg::TS_W-1:0] rsp_smoothed_offset_us;
   logic                             rsp_offset_known;

   logic                             csr_we    = 1'b0;
   logic [nobf_pkg::CSR_IDX_W-1:0]   csr_index = '0;
   logic [nobf_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   int                               mismatch_count;
   int                               results_pending;
   int                               burst_left   = 0;
   bit                               valid_held   = 1'b0;
   bit                               hold_off_due = 1'b0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   ntp_offset_burst_filter_core dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_exchange_ok        (req_exchange_ok),
      .req_send_time_us       (req_send_time_us),
      .req_server_rx_seconds  (req_server_rx_seconds),
      .req_server_rx_fraction (req_server_rx_fraction),
      .req_server_tx_seconds  (req_server_tx_seconds),
      .req_server_tx_fraction (req_server_tx_fraction),
      .req_recv_time_us       (req_recv_time_us),
      .req_last_in_burst      (req_last_in_burst),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_sample_accepted    (rsp_sample_accepted),
      .rsp_sample_offset_us   (rsp_sample_offset_us),
      .rsp_sample_delay_us    (rsp_sample_delay_us),
      .rsp_smoothed_updated   (rsp_smoothed_updated),
      .rsp_smoothed_offset_us (rsp_smoothed_offset_us),
      .rsp_offset_known       (rsp_offset_known),
      .csr_we                 (csr_we),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata)
   );

   offset_filter_checker u_checker (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_exchange_ok        (req_exchange_ok),
      .req_send_time_us       (req_send_time_us),
      .req_server_rx_seconds  (req_server_rx_seconds),
      .req_server_rx_fraction (req_server_rx_fraction),
      .req_server_tx_seconds  (req_server_tx_seconds),
      .req_server_tx_fraction (req_server_tx_fraction),
      .req_recv_time_us       (req_recv_time_us),
      .req_last_in_burst      (req_last_in_burst),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_sample_accepted    (rsp_sample_accepted),
      .rsp_sample_offset_us   (rsp_sample_offset_us),
      .rsp_sample_delay_us    (rsp_sample_delay_us),
      .rsp_smoothed_updated   (rsp_smoothed_updated),
      .rsp_smoothed_offset_us (rsp_smoothed_offset_us),
      .rsp_offset_known       (rsp_offset_known),
      .csr_we                 (csr_we),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .mismatch_count         (mismatch_count),
      .results_pending        (results_pending)
   );

   // Unix microseconds to NTP seconds and fraction; the fraction is rounded up
   // so that it converts back to the same microsecond
   function automatic logic [63:0] ntp_stamp(logic [nobf_pkg::TS_W-1:0] us);
      logic [63:0] rem;
      rem = us % 64'd1000000;
      return {32'(us / 64'd1000000 + 64'd2208988800),
              32'(((rem << 32) + 64'd999999) / 64'd1000000)};
   endfunction

   // Consistent exchange: clock skew plus outbound, server hold and return legs
   function automatic exchange_type shaped_exchange(logic [nobf_pkg::TS_W-1:0] t1,
                                                    longint skew, longint out_us,
                                                    longint back_us, longint hold_us,
                                                    bit ok, bit closes);
      exchange_type              x;
      logic [nobf_pkg::TS_W-1:0] t2;
      logic [nobf_pkg::TS_W-1:0] t3;
      t2 = t1 + skew + out_us;
      t3 = t2 + hold_us;
      x.ok = ok;
      x.t1 = t1;
      {x.rx_sec, x.rx_frac} = ntp_stamp(t2);
      {x.tx_sec, x.tx_frac} = ntp_stamp(t3);
      x.t4 = t3 - skew + back_us;
      x.closes = closes;
      return x;
   endfunction

   // Plausible exchange with random skew scale and leg lengths
   function automatic exchange_type random_exchange(bit ok, bit closes);
      longint                    skew;
      longint                    out_us;
      longint                    back_us;
      logic [nobf_pkg::TS_W-1:0] t1;
      case ($urandom_range(0, 3))
         0:       skew = longint'($urandom_range(0, 2000)) - 1000;
         1:       skew = longint'($urandom_range(0, 2000000)) - 1000000;
         2:       skew = longint'($urandom_range(0, 2000000000)) - 1000000000;
         default: skew = 0;
      endcase
      out_us  = longint'($urandom_range(0, 12000));
      back_us = longint'($urandom_range(0, 12000));
      if ($urandom_range(0, 7) == 0) begin
         out_us  = 0;
         back_us = 0;
      end
      t1 = 64'd1_000_000_000_000_000 + 64'($urandom) * 64'd200000 +
           64'($urandom_range(0, 199999));
      return shaped_exchange(t1, skew, out_us, back_us,
                             longint'($urandom_range(0, 3000)), ok, closes);
   endfunction

   // Exchange with every field random
   function automatic exchange_type noise_exchange();
      exchange_type x;
      x.ok      = 1'($urandom);
      x.t1      = {$urandom, $urandom};
      x.rx_sec  = $urandom;
      x.rx_frac = $urandom;
      x.tx_sec  = $urandom;
      x.tx_frac = $urandom;
      x.t4      = {$urandom, $urandom};
      x.closes  = 1'($urandom);
      return x;
   endfunction

   // Offer one beat, hold it until accepted, then maybe drop valid for a gap
   task automatic offer(exchange_type x);
      int gap;
      req_valid              <= 1'b1;
      req_exchange_ok        <= x.ok;
      req_send_time_us       <= x.t1;
      req_server_rx_seconds  <= x.rx_sec;
      req_server_rx_fraction <= x.rx_frac;
      req_server_tx_seconds  <= x.tx_sec;
      req_server_tx_fraction <= x.tx_frac;
      req_recv_time_us       <= x.t4;
      req_last_in_burst      <= x.closes;
      valid_held = 1'b1;
      do @(posedge clock); while (!req_ready);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) :
                                                    $urandom_range(0, 7);
         if (gap > 0) begin
            req_valid <= 1'b0;
            valid_held = 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Stop offering and wait until every predicted result has come out
   task automatic drain();
      if (valid_held) begin
         req_valid <= 1'b0;
         valid_held = 1'b0;
      end
      do @(posedge clock); while (results_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write both registers while the block is idle
   task automatic configure(logic [nobf_pkg::GAIN_W-1:0] gain,
                            logic [nobf_pkg::RTT_W-1:0] limit);
      drain();
      csr_we    <= 1'b1;
      csr_index <= nobf_pkg::CSR_GAIN;
      csr_wdata <= nobf_pkg::CSR_DATA_W'(gain);
      @(posedge clock);
      csr_index <= nobf_pkg::CSR_MAX_RTT;
      csr_wdata <= limit;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Result side: stall in patterns of its own, with a long hold-off on request
   initial begin
      int span;
      int ready_pct;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_due || $urandom_range(0, 15) == 0) begin
            hold_off_due = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            span = $urandom_range(10, 80);
            case ($urandom_range(0, 3))
               0:       ready_pct = 100;
               1:       ready_pct = 75;
               2:       ready_pct = 40;
               default: ready_pct = 10;
            endcase
            repeat (span) begin
               rsp_ready <= ($urandom_range(1, 100) <= ready_pct);
               @(posedge clock);
            end
         end
      end
   end

   // Stimulus and verdict
   initial begin
      logic [nobf_pkg::TS_W-1:0]   base;
      logic [nobf_pkg::GAIN_W-1:0] gain;
      logic [nobf_pkg::RTT_W-1:0]  limit;
      int                          burst_len;
      int                          sent;
      bit                          dead_burst;
      base = 64'd1_700_000_000_123_456;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // all-zero fields, then all-one fields; zero delay, so load and then smooth
      offer({1'b1, 64'd0, 32'd0, 32'd0, 32'd0, 32'd0, 64'd0, 1'b1});
      offer('1);
      // failed exchange alone in its burst: no update
      offer(shaped_exchange(base, 500, 4000, 3000, 200, 1'b0, 1'b1));
      // equal delays: the earliest stays
      offer(shaped_exchange(base + 64'd1000000, 800, 3000, 2000, 100, 1'b1, 1'b0));
      offer(shaped_exchange(base + 64'd1100000, -800, 2500, 2500, 100, 1'b1, 1'b0));
      offer(shaped_exchange(base + 64'd1200000, 50, 1000, 4000, 100, 1'b1, 1'b1));
      // delay at the limit passes, one above is dropped
      offer(shaped_exchange(base + 64'd2000000, 1200, 10000, 10000, 50, 1'b1, 1'b0));
      offer(shaped_exchange(base + 64'd3000000, -1200, 10001, 10000, 50, 1'b1, 1'b1));
      // odd negative sum halves toward zero
      offer(shaped_exchange(base + 64'd4000000, -1000, 1, 0, 0, 1'b1, 1'b1));
      // server stamps right at the Unix epoch, full fraction
      offer({1'b1, 64'd0, 32'd2208988800, 32'hFFFF_FFFF, 32'd2208988800, 32'd0,
             64'd0, 1'b1});
      // burst closed by a failed exchange still uses its earlier sample
      offer(shaped_exchange(base + 64'd5000000, 300, 700, 900, 10, 1'b1, 1'b0));
      offer(shaped_exchange(base + 64'd6000000, 9999, 100, 100, 10, 1'b0, 1'b1));
      // a later, shorter round trip replaces the best sample
      offer(shaped_exchange(base + 64'd7000000, 2000, 5000, 5000, 10, 1'b1, 1'b0));
      offer(shaped_exchange(base + 64'd8000000, -2000, 100, 100, 10, 1'b1, 1'b1));
      // differences that wrap at 64 bits
      offer({1'b1, 64'h8000_0000_0000_0000, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
             64'h7FFF_FFFF_FFFF_FFFF, 1'b1});
      // large negative skew
      offer(shaped_exchange(base + 64'd9000000, -900000000, 20, 30, 5, 1'b1, 1'b1));

      // random bursts under several register settings
      for (int phase_idx = 0; phase_idx < SETTING_PHASES; phase_idx++) begin
         case (phase_idx)
            0: begin gain = 17'd65536;  limit = 32'd20000;      end
            1: begin gain = 17'd0;      limit = 32'hFFFF_FFFF;  end
            2: begin gain = 17'h1_FFFF; limit = 32'd0;          end
            3: begin gain = 17'd1;      limit = 32'd5000;       end
            default: begin
               gain  = nobf_pkg::GAIN_W'($urandom_range(0, 65536));
               limit = $urandom_range(1000, 30000);
            end
         endcase
         configure(gain, limit);
         if (phase_idx == 0)
            hold_off_due = 1'b1;
         sent = 0;
         while (sent < RANDOM_ITEMS / SETTING_PHASES) begin
            burst_len  = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) :
                                                       $urandom_range(1, 5);
            dead_burst = ($urandom_range(0, 9) == 0);
            for (int k = 0; k < burst_len; k++) begin
               if ($urandom_range(0, 4) == 0)
                  offer(noise_exchange());
               else
                  offer(random_exchange(!dead_burst && $urandom_range(0, 9) != 0,
                                        k == burst_len - 1));
               sent++;
            end
         end
      end

      drain();
      if (mismatch_count == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

   // Hard stop if the run hangs
   initial begin
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("tb_top NOT OK");
      $finish;
   end

endmodule
